// File: sv/mep_pkg.sv
package mep_pkg;

  // fixed point format: signed Q4.FRAC_BITS
  localparam int FRAC_BITS = 28;
  localparam int FX_W      = FRAC_BITS + 4;
  // width of a product after the fraction shift
  localparam int PW        = 2 * FX_W - FRAC_BITS;
  // common width for sums ahead of saturation
  localparam int SAT_W     = 48;

  // field and register widths
  localparam int ITER_W     = 16;
  localparam int LVL_W      = 8;
  localparam int DIM_W      = 13;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 3;

  // axis ranges and bases
  localparam longint RANGE_R_L = (64'sd22 << FRAC_BITS) / 64'sd10;
  localparam int     RANGE_W   = $clog2(RANGE_R_L + 64'sd1);
  localparam logic [RANGE_W-1:0] RANGE_R = RANGE_W'(RANGE_R_L);
  localparam logic [RANGE_W-1:0] RANGE_I = RANGE_W'(64'sd2 << FRAC_BITS);
  localparam logic signed [FX_W-1:0] MIN_R = FX_W'(-((64'sd15 << FRAC_BITS) / 64'sd10));
  localparam logic signed [FX_W-1:0] MIN_I = FX_W'(-(64'sd1 << FRAC_BITS));

  // saturation limits and escape radius squared
  localparam logic signed [FX_W-1:0] FX_MAX = FX_W'((64'sd8 << FRAC_BITS) - 64'sd1);
  localparam logic signed [FX_W-1:0] FX_MIN = FX_W'(-(64'sd8 << FRAC_BITS));
  localparam logic signed [PW:0]     ESCAPE_LIM = (PW + 1)'(64'sd4 << FRAC_BITS);

  // register reset values
  localparam logic [DIM_W-1:0]  RST_WIDTH  = DIM_W'(1920);
  localparam logic [DIM_W-1:0]  RST_HEIGHT = DIM_W'(1080);
  localparam logic [ITER_W-1:0] RST_MAX    = ITER_W'(256);
  localparam logic [LVL_W-1:0]  RST_DIV    = LVL_W'(255);

  // register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMAGE_WIDTH    = 3'd0,
    CFG_IMAGE_HEIGHT   = 3'd1,
    CFG_MAX_ITERATIONS = 3'd2,
    CFG_RED_DIVISOR    = 3'd3,
    CFG_GREEN_DIVISOR  = 3'd4,
    CFG_BLUE_DIVISOR   = 3'd5
  } cfg_idx_t;

  // operand selects: axis during mapping, colour during levels
  localparam logic [1:0] SEL_X     = 2'd0;
  localparam logic [1:0] SEL_Y     = 2'd1;
  localparam logic [1:0] SEL_RED   = 2'd0;
  localparam logic [1:0] SEL_GREEN = 2'd1;
  localparam logic [1:0] SEL_BLUE  = 2'd2;

  // controller to datapath commands
  typedef struct packed {
    logic       load_pix;
    logic       map_mul;
    logic       div_start;
    logic       store_c;
    logic       iter_mul;
    logic       iter_upd;
    logic       store_lvl;
    logic       out_load;
    logic       mod_phase;
    logic [1:0] sel;
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic div_busy;
    logic div_done;
    logic iter_stop;
  } status_t;

  // clamp to the Q4 range
  function automatic logic signed [FX_W-1:0] sat_fx(input logic signed [SAT_W-1:0] v);
    logic signed [FX_W-1:0] r;
    if (v > SAT_W'(FX_MAX)) r = FX_MAX;
    else if (v < SAT_W'(FX_MIN)) r = FX_MIN;
    else r = v[FX_W-1:0];
    return r;
  endfunction

endpackage

// File: sv/mep_div.sv
module mep_div
  import mep_pkg::*;
#(
  parameter int DW = 42,
  parameter int VW = 13
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  output logic          busy,
  output logic          done,
  output logic [DW-1:0] quotient,
  output logic [VW-1:0] remainder
);

  localparam int CW = $clog2(DW + 1);

  logic [DW-1:0] quo_r;
  logic [VW-1:0] rem_r;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [VW:0]   rem_sh;
  logic [VW:0]   rem_sub;
  logic          fits;

  // one restoring step: bring in the next dividend bit and try the subtract
  assign rem_sh  = {rem_r, quo_r[DW-1]};
  assign rem_sub = rem_sh - {1'b0, divisor};
  assign fits    = (rem_sh >= {1'b0, divisor});

  // step counter and handshake
  always_comb begin
    busy_nxt = start | (busy_r & (cnt_r != CW'(1)));
    done_nxt = busy_r & (cnt_r == CW'(1));
    if (start) cnt_nxt = CW'(DW);
    else if (busy_r) cnt_nxt = cnt_r - CW'(1);
    else cnt_nxt = cnt_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // partial remainder and quotient shift register
  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
    end else if (busy_r) begin
      quo_r <= {quo_r[DW-2:0], fits};
      rem_r <= fits ? rem_sub[VW-1:0] : rem_sh[VW-1:0];
    end
  end

  assign busy      = busy_r;
  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

`ifndef SYNTH
  a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !busy_r)
    else $error("divider started while busy");
`endif

endmodule

// File: sv/mep_ctrl.sv
module mep_ctrl
  import mep_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_stall,
  output logic    out_valid,
  input  logic    out_stall,
  output cmd_t    cmd,
  input  status_t status
);

  typedef enum logic [6:0] {
    S_IDLE     = 7'b0000001,
    S_MAP_MUL  = 7'b0000010,
    S_DIV_GO   = 7'b0000100,
    S_DIV_WAIT = 7'b0001000,
    S_ITER_MUL = 7'b0010000,
    S_ITER_UPD = 7'b0100000,
    S_FLUSH    = 7'b1000000
  } state_t;

  state_t     state_r, state_nxt;
  logic       mod_r, mod_nxt;
  logic [1:0] sel_r, sel_nxt;
  logic       out_valid_r, out_valid_nxt;

  // sequencing of mapping, iteration and colour levels
  always_comb begin
    state_nxt     = state_r;
    mod_nxt       = mod_r;
    sel_nxt       = sel_r;
    cmd           = '0;
    cmd.sel       = sel_r;
    cmd.mod_phase = mod_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_pix = 1'b1;
          mod_nxt      = 1'b0;
          sel_nxt      = SEL_X;
          state_nxt    = S_MAP_MUL;
        end
      end
      S_MAP_MUL: begin
        cmd.map_mul = 1'b1;
        state_nxt   = S_DIV_GO;
      end
      S_DIV_GO: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_DIV_WAIT;
      end
      S_DIV_WAIT: begin
        if (status.div_done) begin
          if (mod_r) begin
            cmd.store_lvl = 1'b1;
            if (sel_r == SEL_BLUE) begin
              state_nxt = S_FLUSH;
            end else begin
              sel_nxt   = sel_r + 2'd1;
              state_nxt = S_DIV_GO;
            end
          end else begin
            cmd.store_c = 1'b1;
            if (sel_r == SEL_X) begin
              sel_nxt   = SEL_Y;
              state_nxt = S_MAP_MUL;
            end else begin
              state_nxt = S_ITER_MUL;
            end
          end
        end
      end
      S_ITER_MUL: begin
        cmd.iter_mul = 1'b1;
        state_nxt    = S_ITER_UPD;
      end
      S_ITER_UPD: begin
        if (status.iter_stop) begin
          mod_nxt   = 1'b1;
          sel_nxt   = SEL_RED;
          state_nxt = S_DIV_GO;
        end else begin
          cmd.iter_upd = 1'b1;
          state_nxt    = S_ITER_MUL;
        end
      end
      S_FLUSH: begin
        if (!out_valid_r || !out_stall) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // output word held until taken
  assign out_valid_nxt = cmd.out_load | (out_valid_r & out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      mod_r       <= 1'b0;
      sel_r       <= SEL_X;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      mod_r       <= mod_nxt;
      sel_r       <= sel_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

`ifndef SYNTH
  a_accept_starts_map: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r == S_MAP_MUL))
    else $error("accepted word did not start mapping");

  a_result_from_flush: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_FLUSH))
    else $error("result raised outside flush");
`endif

endmodule

// File: sv/mep_dp.sv
module mep_dp
  import mep_pkg::*;
#(
  parameter int COORD_WIDTH = 12
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  cmd_t                   cmd,
  output status_t                status,
  input  logic [COORD_WIDTH-1:0] pixel_x,
  input  logic [COORD_WIDTH-1:0] pixel_y,
  input  logic                   cfg_wr,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output logic [ITER_W-1:0]      escape_count,
  output logic [LVL_W-1:0]       red_level,
  output logic [LVL_W-1:0]       green_level,
  output logic [LVL_W-1:0]       blue_level
);

  localparam int DW = COORD_WIDTH + RANGE_W;

  // configuration registers
  logic [DIM_W-1:0]  width_r, height_r;
  logic [ITER_W-1:0] max_r;
  logic [LVL_W-1:0]  rdiv_r, gdiv_r, bdiv_r;

  // working registers
  logic [COORD_WIDTH-1:0] pix_x_r, pix_y_r;
  logic [DW-1:0]          prod_r;
  logic signed [FX_W-1:0] cr_r, ci_r, zr_r, zi_r;
  logic signed [PW-1:0]   sr_r, si_r, pri_r;
  logic [ITER_W-1:0]      count_r;
  logic [LVL_W-1:0]       red_r, green_r, blue_r;
  logic [ITER_W-1:0]      out_count_r;
  logic [LVL_W-1:0]       out_red_r, out_green_r, out_blue_r;

  // combinational terms
  logic [COORD_WIDTH-1:0]   pix_sel;
  logic [RANGE_W-1:0]       range_sel;
  logic [DW-1:0]            prod_nxt;
  logic [DIM_W-1:0]         dim_w, dim_h;
  logic [LVL_W-1:0]         cdiv_sel;
  logic [DW-1:0]            div_dividend;
  logic [DIM_W-1:0]         div_divisor;
  logic                     div_busy, div_done;
  logic [DW-1:0]            div_quo;
  logic [DIM_W-1:0]         div_rem;
  logic signed [FX_W-1:0]   base_sel;
  logic signed [SAT_W-1:0]  map_sum;
  logic signed [FX_W-1:0]   c_nxt;
  logic [LVL_W-1:0]         lvl_nxt;
  logic signed [2*FX_W-1:0] p_rr, p_ii, p_ri;
  logic signed [PW:0]       esc_sum;
  logic signed [SAT_W-1:0]  zi_sum, zr_sum;
  logic                     iter_stop;

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= RST_WIDTH;
      height_r <= RST_HEIGHT;
      max_r    <= RST_MAX;
      rdiv_r   <= RST_DIV;
      gdiv_r   <= RST_DIV;
      bdiv_r   <= RST_DIV;
    end else if (cfg_wr) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_IMAGE_WIDTH:    width_r  <= cfg_data[DIM_W-1:0];
        CFG_IMAGE_HEIGHT:   height_r <= cfg_data[DIM_W-1:0];
        CFG_MAX_ITERATIONS: max_r    <= cfg_data[ITER_W-1:0];
        CFG_RED_DIVISOR:    rdiv_r   <= cfg_data[LVL_W-1:0];
        CFG_GREEN_DIVISOR:  gdiv_r   <= cfg_data[LVL_W-1:0];
        CFG_BLUE_DIVISOR:   bdiv_r   <= cfg_data[LVL_W-1:0];
        default: ;
      endcase
    end
  end

  // coordinate scaling ahead of the divide
  assign pix_sel   = (cmd.sel == SEL_X) ? pix_x_r : pix_y_r;
  assign range_sel = (cmd.sel == SEL_X) ? RANGE_R : RANGE_I;
  assign prod_nxt  = DW'(pix_sel) * DW'(range_sel);

  // a zero span counts as one
  assign dim_w = (width_r == '0) ? DIM_W'(1) : width_r;
  assign dim_h = (height_r == '0) ? DIM_W'(1) : height_r;

  always_comb begin
    unique case (cmd.sel)
      SEL_RED:   cdiv_sel = rdiv_r;
      SEL_GREEN: cdiv_sel = gdiv_r;
      default:   cdiv_sel = bdiv_r;
    endcase
  end

  // shared divider operands: span during mapping, colour divisor during levels
  assign div_dividend = cmd.mod_phase ? DW'(count_r) : prod_r;
  assign div_divisor  = cmd.mod_phase ? DIM_W'(cdiv_sel) :
                        ((cmd.sel == SEL_X) ? dim_w : dim_h);

  mep_div #(
    .DW (DW),
    .VW (DIM_W)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (cmd.div_start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .busy      (div_busy),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  // base plus offset, clamped
  assign base_sel = (cmd.sel == SEL_X) ? MIN_R : MIN_I;
  assign map_sum  = SAT_W'(signed'({1'b0, div_quo})) + SAT_W'(base_sel);
  assign c_nxt    = sat_fx(map_sum);

  // zero divisor gives a zero level
  assign lvl_nxt = (cdiv_sel == '0) ? '0 : div_rem[LVL_W-1:0];

  // squares and cross product, floor after the fraction shift
  assign p_rr = zr_r * zr_r;
  assign p_ii = zi_r * zi_r;
  assign p_ri = zr_r * zi_r;

  // escape test and next z
  assign esc_sum   = (PW + 1)'(sr_r) + (PW + 1)'(si_r);
  assign iter_stop = (count_r >= max_r) || (esc_sum >= ESCAPE_LIM);
  assign zi_sum    = SAT_W'(pri_r) + SAT_W'(pri_r) + SAT_W'(ci_r);
  assign zr_sum    = SAT_W'(sr_r) - SAT_W'(si_r) + SAT_W'(cr_r);

  always_ff @(posedge clk) begin
    if (cmd.load_pix) begin
      pix_x_r <= pixel_x;
      pix_y_r <= pixel_y;
      zr_r    <= '0;
      zi_r    <= '0;
      count_r <= '0;
    end
    if (cmd.map_mul) prod_r <= prod_nxt;
    if (cmd.store_c) begin
      if (cmd.sel == SEL_X) cr_r <= c_nxt;
      else ci_r <= c_nxt;
    end
    if (cmd.iter_mul) begin
      sr_r  <= p_rr[2*FX_W-1:FRAC_BITS];
      si_r  <= p_ii[2*FX_W-1:FRAC_BITS];
      pri_r <= p_ri[2*FX_W-1:FRAC_BITS];
    end
    if (cmd.iter_upd) begin
      zr_r    <= sat_fx(zr_sum);
      zi_r    <= sat_fx(zi_sum);
      count_r <= count_r + ITER_W'(1);
    end
    if (cmd.store_lvl) begin
      unique case (cmd.sel)
        SEL_RED:   red_r   <= lvl_nxt;
        SEL_GREEN: green_r <= lvl_nxt;
        default:   blue_r  <= lvl_nxt;
      endcase
    end
    if (cmd.out_load) begin
      out_count_r <= count_r;
      out_red_r   <= red_r;
      out_green_r <= green_r;
      out_blue_r  <= blue_r;
    end
  end

  assign status.div_busy  = div_busy;
  assign status.div_done  = div_done;
  assign status.iter_stop = iter_stop;

  assign escape_count = out_count_r;
  assign red_level    = out_red_r;
  assign green_level  = out_green_r;
  assign blue_level   = out_blue_r;

`ifndef SYNTH
  a_count_steps: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.iter_upd |=> (count_r == $past(count_r) + ITER_W'(1)))
    else $error("iteration count did not advance by one");

  a_level_after_divide: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.store_lvl |-> (div_done && !div_busy))
    else $error("level stored without a finished divide");
`endif

endmodule

// File: sv/mandelbrot_escape_pixel.sv
// Mandelbrot escape-time pixel evaluator, signed Q4.28 fixed point.
// Input channel: in_valid / in_stall with in_pixel_x and in_pixel_y, one word
//   per pixel; the word is taken when in_valid is high and in_stall low.
// Result channel: out_valid / out_stall with the escape count and the red,
//   green and blue levels (count modulo each divisor, zero for a zero divisor).
// Configuration: cfg_valid / cfg_ready with cfg_index and cfg_data; cfg_ready
//   is always high and a write lands on the next edge. Write only while idle.
// Operation: each iteration multiplies, then adds and clamps. One shared
//   restoring divider, one bit a cycle over COORD_WIDTH + 30 bits, runs five
//   times: both axis mappings and the three colour levels.
// Throughput: one pixel at a time; in_stall is high from accept until the
//   result moves into the output register.
// Stall: a finished result waits in the output register while out_stall is
//   high, and the next pixel can be accepted and worked meanwhile; a second
//   result waits inside until the register empties.
// Reset: synchronous, active low; registers return to 1920 x 1080, limit 256,
//   divisors 255, and any pixel in progress is dropped.
module mandelbrot_escape_pixel
  import mep_pkg::*;
#(
  parameter int COORD_WIDTH = 12
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [COORD_WIDTH-1:0] in_pixel_x,
  input  logic [COORD_WIDTH-1:0] in_pixel_y,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [ITER_W-1:0]      out_escape_count,
  output logic [LVL_W-1:0]       out_red_level,
  output logic [LVL_W-1:0]       out_green_level,
  output logic [LVL_W-1:0]       out_blue_level,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  cmd_t    cmd;
  status_t status;

  // registers accept a word every cycle
  assign cfg_ready = 1'b1;

  mep_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .status    (status)
  );

  mep_dp #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .status       (status),
    .pixel_x      (in_pixel_x),
    .pixel_y      (in_pixel_y),
    .cfg_wr       (cfg_valid),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .escape_count (out_escape_count),
    .red_level    (out_red_level),
    .green_level  (out_green_level),
    .blue_level   (out_blue_level)
  );

endmodule

// File: test/tb_mandelbrot_escape_pixel.sv
`timescale 1ns / 1ps

module tb_mandelbrot_escape_pixel;
  import mep_pkg::*;

  localparam int COORD_W = 12;
  localparam int QUIET_LIMIT = 400000;
  localparam int SETTLE_CYCLES = 300;

  // fixed point constants, signed Q4 with FRAC_BITS fraction bits
  localparam longint Q4_HI   = (64'sd8 << FRAC_BITS) - 64'sd1;
  localparam longint Q4_LO   = -(64'sd8 << FRAC_BITS);
  localparam longint SPAN_RE = (64'sd22 << FRAC_BITS) / 64'sd10;
  localparam longint BASE_RE = -((64'sd15 << FRAC_BITS) / 64'sd10);
  localparam longint SPAN_IM = 64'sd2 << FRAC_BITS;
  localparam longint BASE_IM = -(64'sd1 << FRAC_BITS);
  localparam longint ESCAPE  = 64'sd4 << FRAC_BITS;

  typedef struct packed {
    logic [ITER_W-1:0] escape_count;
    logic [LVL_W-1:0]  red_level;
    logic [LVL_W-1:0]  green_level;
    logic [LVL_W-1:0]  blue_level;
  } colour_t;

  // register copy, escape-time prediction and the colours still awaited
  class colour_ledger;
    logic [DIM_W-1:0]  width_reg;
    logic [DIM_W-1:0]  height_reg;
    logic [ITER_W-1:0] iter_limit;
    logic [LVL_W-1:0]  red_div;
    logic [LVL_W-1:0]  green_div;
    logic [LVL_W-1:0]  blue_div;
    colour_t           awaited[$];
    int unsigned       mismatches;
    int unsigned       checked;
    int unsigned       deepest;

    function new();
      width_reg  = RST_WIDTH;
      height_reg = RST_HEIGHT;
      iter_limit = RST_MAX;
      red_div    = RST_DIV;
      green_div  = RST_DIV;
      blue_div   = RST_DIV;
      mismatches = 0;
      checked    = 0;
      deepest    = 0;
    endfunction

    function void write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_IMAGE_WIDTH:    width_reg  = data[DIM_W-1:0];
        CFG_IMAGE_HEIGHT:   height_reg = data[DIM_W-1:0];
        CFG_MAX_ITERATIONS: iter_limit = data[ITER_W-1:0];
        CFG_RED_DIVISOR:    red_div    = data[LVL_W-1:0];
        CFG_GREEN_DIVISOR:  green_div  = data[LVL_W-1:0];
        CFG_BLUE_DIVISOR:   blue_div   = data[LVL_W-1:0];
        default: ;
      endcase
    endfunction

    function longint clamp_q4(longint v);
      if (v > Q4_HI) return Q4_HI;
      if (v < Q4_LO) return Q4_LO;
      return v;
    endfunction

    // full product, floor shift back to Q4
    function longint fx_mul(longint a, longint b);
      return (a * b) >>> FRAC_BITS;
    endfunction

    // linear map of a coordinate onto one axis, zero span counts as one
    function longint axis_point(longint pos, longint span, longint range, longint base);
      longint d;
      d = (span == 0) ? 64'sd1 : span;
      return clamp_q4(base + (pos * range) / d);
    endfunction

    function logic [LVL_W-1:0] level_of(int unsigned n, logic [LVL_W-1:0] d);
      return (d == 0) ? '0 : LVL_W'(n % d);
    endfunction

    function colour_t colour_of(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y);
      longint      cr, ci, zr, zi, sr, si, nzi;
      int unsigned n;
      colour_t     c;
      cr = axis_point(x, width_reg, SPAN_RE, BASE_RE);
      ci = axis_point(y, height_reg, SPAN_IM, BASE_IM);
      zr = 0;
      zi = 0;
      n  = 0;
      // z = z*z + c until escape or the limit
      while (1) begin
        sr = fx_mul(zr, zr);
        si = fx_mul(zi, zi);
        if (n >= iter_limit || sr + si >= ESCAPE) break;
        nzi = clamp_q4(2 * fx_mul(zr, zi) + ci);
        zr  = clamp_q4(sr - si + cr);
        zi  = nzi;
        n++;
      end
      c.escape_count = ITER_W'(n);
      c.red_level    = level_of(n, red_div);
      c.green_level  = level_of(n, green_div);
      c.blue_level   = level_of(n, blue_div);
      return c;
    endfunction

    function void note_pixel(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y);
      awaited.push_back(colour_of(x, y));
    endfunction

    // four-state compare so unknown outputs never slip through
    function void compare_field(string field, logic [ITER_W-1:0] want, logic [ITER_W-1:0] got);
      if (want !== got) begin
        $error("%s: expected %0d, got %0d", field, want, got);
        mismatches++;
      end
    endfunction

    function void check_colour(colour_t got);
      colour_t want;
      if (awaited.size() == 0) begin
        $error("escape result with no pixel outstanding, count %0d", got.escape_count);
        mismatches++;
        return;
      end
      want = awaited.pop_front();
      checked++;
      if (want.escape_count > deepest) deepest = want.escape_count;
      compare_field("escape_count", want.escape_count, got.escape_count);
      compare_field("red_level", ITER_W'(want.red_level), ITER_W'(got.red_level));
      compare_field("green_level", ITER_W'(want.green_level), ITER_W'(got.green_level));
      compare_field("blue_level", ITER_W'(want.blue_level), ITER_W'(got.blue_level));
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  logic [COORD_W-1:0]    in_pixel_x;
  logic [COORD_W-1:0]    in_pixel_y;
  logic                  out_valid;
  logic                  out_stall;
  logic [ITER_W-1:0]     out_escape_count;
  logic [LVL_W-1:0]      out_red_level;
  logic [LVL_W-1:0]      out_green_level;
  logic [LVL_W-1:0]      out_blue_level;
  logic                  cfg_valid;
  logic                  cfg_ready;
  cfg_idx_t              cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  colour_ledger book = new();
  bit           steady;
  int unsigned  pixels_sent = 0;
  int unsigned  reg_writes = 0;
  int unsigned  quiet_cycles = 0;

  mandelbrot_escape_pixel #(
    .COORD_WIDTH(COORD_W)
  ) i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_pixel_x       (in_pixel_x),
    .in_pixel_y       (in_pixel_y),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_escape_count (out_escape_count),
    .out_red_level    (out_red_level),
    .out_green_level  (out_green_level),
    .out_blue_level   (out_blue_level),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  // 8 ns clock
  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // idle cycles per word, none during steady stretches
  function automatic int unsigned pick_gap();
    return steady ? 0 : $urandom_range(0, 6);
  endfunction

  // one pixel word; valid stays up until the next call decides
  task automatic send_pixel(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y);
    int unsigned gap;
    gap = pick_gap();
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid   <= 1'b1;
    in_pixel_x <= x;
    in_pixel_y <= y;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    book.note_pixel(x, y);
    pixels_sent++;
  endtask

  // stop sending and wait for every outstanding colour
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    @(posedge clk);
    while (book.awaited.size() != 0) @(posedge clk);
  endtask

  task automatic set_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (cfg_ready !== 1'b1) @(posedge clk);
    book.write_reg(idx, data);
    reg_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // image dimension word, now and then with bits above the register
  function automatic logic [CFG_DATA_W-1:0] pick_dim();
    case ($urandom_range(0, 7))
      0: return 16'd1;
      1: return 16'd4096;
      2: return 16'($urandom());
      3, 4: return 16'($urandom_range(1, 64));
      default: return 16'($urandom_range(1, 4096));
    endcase
  endfunction

  // divisor in the low byte, random upper byte
  function automatic logic [CFG_DATA_W-1:0] pick_divisor();
    logic [LVL_W-1:0] d;
    case ($urandom_range(0, 5))
      0: d = 8'd0;
      1: d = 8'd1;
      2: d = 8'd255;
      default: d = 8'($urandom_range(0, 255));
    endcase
    return {8'($urandom_range(0, 255)), d};
  endfunction

  // new register setting, then pixels mostly inside the image
  task automatic random_phase(input int unsigned items, input bit long_limit,
                              input bit calm);
    int unsigned        span_x, span_y;
    logic [COORD_W-1:0] x, y;
    drain();
    steady = calm || ($urandom_range(0, 3) == 0);
    set_reg(CFG_IMAGE_WIDTH, pick_dim());
    set_reg(CFG_IMAGE_HEIGHT, pick_dim());
    set_reg(CFG_MAX_ITERATIONS, long_limit ? 16'd256 : 16'($urandom_range(0, 40)));
    set_reg(CFG_RED_DIVISOR, pick_divisor());
    set_reg(CFG_GREEN_DIVISOR, pick_divisor());
    set_reg(CFG_BLUE_DIVISOR, pick_divisor());
    span_x = (book.width_reg == 0) ? 1 : (book.width_reg > 4096 ? 4096 : book.width_reg);
    span_y = (book.height_reg == 0) ? 1 : (book.height_reg > 4096 ? 4096 : book.height_reg);
    for (int i = 0; i < items; i++) begin
      if ($urandom_range(0, 6) == 0) begin
        x = COORD_W'($urandom());
        y = COORD_W'($urandom());
      end else begin
        x = COORD_W'($urandom_range(0, span_x - 1));
        y = COORD_W'($urandom_range(0, span_y - 1));
      end
      send_pixel(x, y);
      if ($urandom_range(0, 40) == 0) drain();
    end
  endtask

  // result side: stall for a drawn number of cycles once a word shows
  initial begin : result_sink
    int unsigned hold;
    colour_t     got;
    out_stall = 1'b0;
    @(posedge rst_n);
    forever begin
      hold = pick_gap();
      @(negedge clk);
      out_stall <= (hold != 0);
      @(posedge clk);
      while (out_valid !== 1'b1) @(posedge clk);
      if (hold != 0) begin
        repeat (hold - 1) @(posedge clk);
        @(negedge clk);
        out_stall <= 1'b0;
        @(posedge clk);
      end
      got.escape_count = out_escape_count;
      got.red_level    = out_red_level;
      got.green_level  = out_green_level;
      got.blue_level   = out_blue_level;
      book.check_colour(got);
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $error("no handshake for %0d cycles, %0d colours outstanding",
             QUIET_LIMIT, book.awaited.size());
      $display("FAILED: results differ");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_pixel_x = '0;
    in_pixel_y = '0;
    cfg_valid  = 1'b0;
    cfg_index  = CFG_IMAGE_WIDTH;
    cfg_data   = '0;
    steady     = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset setting: corners, an interior point, a column beyond the image
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd4095, 12'd4095);
    send_pixel(12'd1919, 12'd1079);
    send_pixel(12'd960, 12'd540);
    send_pixel(12'd4095, 12'd0);

    // zero width and height act as one, far coordinates saturate c
    drain();
    set_reg(CFG_IMAGE_WIDTH, 16'd0);
    set_reg(CFG_IMAGE_HEIGHT, 16'd0);
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd1, 12'd1);
    send_pixel(12'd4095, 12'd4095);
    send_pixel(12'd0, 12'd4095);

    // zero iteration limit, zero and unit divisors, widest image
    drain();
    set_reg(CFG_IMAGE_WIDTH, 16'd4096);
    set_reg(CFG_IMAGE_HEIGHT, 16'd4096);
    set_reg(CFG_MAX_ITERATIONS, 16'd0);
    set_reg(CFG_RED_DIVISOR, 16'd1);
    set_reg(CFG_GREEN_DIVISOR, 16'd0);
    set_reg(CFG_BLUE_DIVISOR, 16'd255);
    send_pixel(12'd2048, 12'd2048);
    send_pixel(12'd0, 12'd0);

    // full iteration limit on c near -1, which never escapes, and two points that escape
    drain();
    set_reg(CFG_IMAGE_WIDTH, 16'd22);
    set_reg(CFG_IMAGE_HEIGHT, 16'd2);
    set_reg(CFG_MAX_ITERATIONS, 16'd65535);
    set_reg(CFG_GREEN_DIVISOR, 16'd128);
    set_reg(CFG_BLUE_DIVISOR, 16'd3);
    send_pixel(12'd5, 12'd1);
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd21, 12'd1);

    // random settings and pixels
    for (int p = 0; p < 10; p++) random_phase(110, (p % 4) == 3, p == 0);

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("checked %0d escape results from %0d pixels over %0d register writes",
             book.checked, pixels_sent, reg_writes);
    $display("deepest escape count seen %0d", book.deepest);
    if (book.mismatches == 0 && book.awaited.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
